### hw/rtl/sai2x_pkg.sv
// Package for the 2xSaI 2x2 upscaler: pixel and request types, channel constants.
package sai2x_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int PIX_W        = 24;
  localparam int ROWS         = 4;
  localparam int COLS         = 4;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t row0_pixel;
    pix_t row1_pixel;
    pix_t row2_pixel;
    pix_t row3_pixel;
    logic last_column;
  } in_req_t;

  typedef struct packed {
    pix_t upper_left;
    pix_t upper_right;
    pix_t lower_left;
    pix_t lower_right;
    logic end_of_line;
  } out_req_t;

  // column offset of a kernel pass: regular, first flush, final flush
  typedef enum logic [1:0] {
    SHIFT_REG   = 2'd0,
    SHIFT_FLUSH = 2'd1,
    SHIFT_LAST  = 2'd2
  } shift_t;

endpackage

### hw/rtl/sai_2x_upscale_2x2.sv
// 2xSaI 2x2 upscaler top level: column window, result sequencer and kernel.
// Takes one source column (four rows, y-1..y+2) per request and returns one 2x2
// output block per source column. A column's block leaves once column x+2 has
// arrived; the columns still pending are flushed when the last column arrives.
// Mid-line, while out_stall is low, the block takes one request per cycle and returns one result
// per cycle; each request passes through the window and pending-pass registers before its result is
// registered at the output. A request marked last_column makes up to three results; the input is
// stalled while the single kernel produces them from the four-column window register.
// A result held by out_stall also holds the input for as long as it waits.
// Edge columns are replicated at both ends of the line.
module sai_2x_upscale_2x2 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sai2x_pkg::in_req_t  in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output sai2x_pkg::out_req_t out_req
);
  import sai2x_pkg::*;

  pix_t     win_r [ROWS][COLS];
  logic [1:0] seen_r, seen_nxt;
  logic [2:0] pend_r, pend_nxt, pend_new, pend_left, pend_pick;
  logic     out_valid_r, out_valid_nxt;
  out_req_t out_req_r, out_req_nxt;

  logic     accept, out_load, issue;
  shift_t   shift;
  pix_t     inc [ROWS];
  pix_t     c [ROWS][COLS];
  logic [2:0] ix;
  logic [1:0] col;

  pix_t     pI, pE, pF, pJ, pG, pA, pB, pK, pH, pC, pD, pL, pM, pN, pO;
  pix_t     ur, ll, lr, mab, mac;
  logic [2:0] vote_a, vote_b;

  function automatic pix_t mix(pix_t p, pix_t q);
    pix_t                  r;
    logic [CHANNEL_BITS:0] s;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      s = {1'b0, p[i*CHANNEL_BITS +: CHANNEL_BITS]} + {1'b0, q[i*CHANNEL_BITS +: CHANNEL_BITS]};
      r[i*CHANNEL_BITS +: CHANNEL_BITS] = s[CHANNEL_BITS:1];
    end
    return r;
  endfunction

  assign inc[0] = in_req.row0_pixel;
  assign inc[1] = in_req.row1_pixel;
  assign inc[2] = in_req.row2_pixel;
  assign inc[3] = in_req.row3_pixel;

  // sequencer: lowest pending pass goes first
  always_comb begin
    if (pend_r[0]) begin
      shift     = SHIFT_REG;
      pend_pick = 3'b001;
    end else if (pend_r[1]) begin
      shift     = SHIFT_FLUSH;
      pend_pick = 3'b010;
    end else begin
      shift     = SHIFT_LAST;
      pend_pick = 3'b100;
    end
    out_load  = !out_valid_r || !out_stall;
    issue     = (pend_r != 3'b000) && out_load;
    pend_left = issue ? (pend_r & ~pend_pick) : pend_r;
    in_stall  = (pend_left != 3'b000);
    accept    = in_valid && !in_stall;

    pend_new[0] = (seen_r >= 2'd2);
    pend_new[1] = in_req.last_column && (seen_r >= 2'd1);
    pend_new[2] = in_req.last_column;
    pend_nxt    = accept ? pend_new : pend_left;

    if (!accept) begin
      seen_nxt = seen_r;
    end else if (in_req.last_column) begin
      seen_nxt = 2'd0;
    end else if (seen_r == 2'd3) begin
      seen_nxt = seen_r;
    end else begin
      seen_nxt = seen_r + 2'd1;
    end

    out_valid_nxt = issue ? 1'b1 : (out_load ? 1'b0 : out_valid_r);
  end

  // neighbourhood: columns clamped to the newest window column
  always_comb begin
    for (int k = 0; k < COLS; k++) begin
      ix  = 3'(k) + {1'b0, shift};
      col = (ix > 3'd3) ? 2'd3 : ix[1:0];
      for (int r = 0; r < ROWS; r++) begin
        c[r][k] = win_r[r][col];
      end
    end
  end

  // 2xSaI kernel
  always_comb begin
    pI = c[0][0]; pE = c[0][1]; pF = c[0][2]; pJ = c[0][3];
    pG = c[1][0]; pA = c[1][1]; pB = c[1][2]; pK = c[1][3];
    pH = c[2][0]; pC = c[2][1]; pD = c[2][2]; pL = c[2][3];
    pM = c[3][0]; pN = c[3][1]; pO = c[3][2];
    mab    = mix(pA, pB);
    mac    = mix(pA, pC);
    vote_a = '0;
    vote_b = '0;
    if (pE == pG) begin
      if (pA == pE) vote_b = vote_b + 3'd1;
      else if (pB == pE) vote_a = vote_a + 3'd1;
    end
    if (pF == pK) begin
      if (pA == pF) vote_b = vote_b + 3'd1;
      else if (pB == pF) vote_a = vote_a + 3'd1;
    end
    if (pH == pN) begin
      if (pA == pH) vote_b = vote_b + 3'd1;
      else if (pB == pH) vote_a = vote_a + 3'd1;
    end
    if (pL == pO) begin
      if (pA == pL) vote_b = vote_b + 3'd1;
      else if (pB == pL) vote_a = vote_a + 3'd1;
    end

    if (pA == pD && pB != pC) begin
      ur = ((pA == pE && pB == pL) || (pA == pC && pA == pF && pB != pE && pB == pJ))
           ? pA : mab;
      ll = ((pA == pG && pC == pO) || (pA == pB && pA == pH && pG != pC && pC == pM))
           ? pA : mac;
      lr = pA;
    end else if (pB == pC && pA != pD) begin
      ur = ((pB == pF && pA == pH) || (pB == pE && pB == pD && pA != pF && pA == pI))
           ? pB : mab;
      ll = ((pC == pH && pA == pF) || (pC == pG && pC == pD && pA != pH && pA == pI))
           ? pC : mac;
      lr = pB;
    end else if (pA == pD && pB == pC) begin
      if (pA == pB) begin
        ur = pA;
        ll = pA;
        lr = pA;
      end else begin
        ur = mab;
        ll = mab;
        if (vote_a > vote_b) lr = pA;
        else if (vote_a < vote_b) lr = pB;
        else lr = mab;
      end
    end else begin
      if (pA == pC && pA == pF && pB != pE && pB == pJ) ur = pA;
      else if (pB == pE && pB == pD && pA != pF && pA == pI) ur = pB;
      else ur = mab;
      if (pA == pB && pA == pH && pG != pC && pC == pM) ll = pA;
      else if (pC == pG && pC == pD && pA != pH && pA == pI) ll = pC;
      else ll = mac;
      lr = mix(mab, mix(pC, pD));
    end

    out_req_nxt.upper_left  = pA;
    out_req_nxt.upper_right = ur;
    out_req_nxt.lower_left  = ll;
    out_req_nxt.lower_right = lr;
    out_req_nxt.end_of_line = (shift == SHIFT_LAST);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 2'd0;
      pend_r      <= 3'b000;
      out_valid_r <= 1'b0;
    end else begin
      seen_r      <= seen_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // window: first column of a line fills every slot
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int r = 0; r < ROWS; r++) begin
        if (seen_r == 2'd0) begin
          for (int k = 0; k < COLS; k++) begin
            win_r[r][k] <= inc[r];
          end
        end else begin
          for (int k = 0; k < COLS - 1; k++) begin
            win_r[r][k] <= win_r[r][k+1];
          end
          win_r[r][COLS-1] <= inc[r];
        end
      end
    end
    if (issue) begin
      out_req_r <= out_req_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule
